[src/fbfl_pkg.sv]
`timescale 1ns / 1ps

package fbfl_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int LINK_BYTES_DEF = 8;

  // Capacity chosen when pool_capacity is written as zero
  localparam int DEFAULT_BLOCKS = 8;

  // Fixed field widths
  localparam int CAP_W      = 9;
  localparam int BYTES_W    = 16;
  localparam int IDX_W      = 8;
  localparam int OFFSET_W   = 24;
  localparam int USED_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [USED_W-1:0]  USED_MAX    = 9'd511;
  localparam logic [CAP_W-1:0]   CAP_RESET   = 9'd8;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd1;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RECYCLE = 1'b1
  } mode_t;

endpackage

[src/fbfl_req_if.sv]
`timescale 1ns / 1ps

interface fbfl_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [fbfl_pkg::IDX_W-1:0] block_index;

  modport source (output valid, output mode, output block_index, input ready);
  modport sink   (input valid, input mode, input block_index, output ready);
endinterface

[src/fbfl_rsp_if.sv]
`timescale 1ns / 1ps

interface fbfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [fbfl_pkg::IDX_W-1:0]    given_index;
  logic [fbfl_pkg::OFFSET_W-1:0] byte_offset;
  logic [fbfl_pkg::USED_W-1:0]   used_count;

  modport source (output valid, output granted, output given_index, output byte_offset,
                  output used_count, input ready);
  modport sink   (input valid, input granted, input given_index, input byte_offset,
                  input used_count, output ready);
endinterface

[src/fbfl_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fixed_block_free_list_allocator_unit.sv]
`timescale 1ns / 1ps

// Fixed-size block allocator. Blocks are kept on a singly linked free list: a head
// index in a register and one next-link per block in a RAM. An allocate request pops
// the head and returns its index and byte offset (index * (block_bytes + LINK_BYTES)
// + LINK_BYTES, wrapped to 24 bits), or granted = 0 when the list is empty. A recycle
// request pushes block_index back on the head; indexes at or past the effective
// capacity are refused. Each response carries the in-use count after the request.
// An allocate that gets a block passes through a pop state, since the next link must be
// read from the RAM before the head can move; a recycle or a failed allocate does not.
// After reset and after each pool_capacity write the link RAM is rebuilt by a
// clearing pass of one entry per cycle over the effective capacity (8 entries after
// reset); no request transfer is taken during it. Configuration writes land
// at once and are meant for idle periods only.
module fixed_block_free_list_allocator_unit #(
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int LINK_BYTES = fbfl_pkg::LINK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
  fbfl_req_if.sink                        req,
  fbfl_rsp_if.source                      rsp
);

  // Address, link (holds the empty mark MAX_BLOCKS), compare and product widths
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (LW > fbfl_pkg::CAP_W) ? LW : fbfl_pkg::CAP_W;
  localparam int SW = fbfl_pkg::BYTES_W + 1;
  localparam int OW = (LW + SW + 1 > fbfl_pkg::OFFSET_W) ? LW + SW + 1 : fbfl_pkg::OFFSET_W;

  localparam logic [LW-1:0] EMPTY = LW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,  // clearing pass over the link RAM
    ST_IDLE = 3'b010,  // ready for a request
    ST_POP  = 3'b100   // link read in flight, head moves at the end
  } state_t;

  state_t                          state;
  logic [fbfl_pkg::CAP_W-1:0]      pool_capacity;
  logic [fbfl_pkg::BYTES_W-1:0]    block_bytes;
  logic [LW-1:0]                   head;
  logic [fbfl_pkg::USED_W-1:0]     in_use;
  logic [fbfl_pkg::USED_W-1:0]     in_use_next;
  logic [AW-1:0]                   sweep_idx;

  // Output register
  logic                            out_valid;
  logic                            out_granted;
  logic [fbfl_pkg::IDX_W-1:0]      out_index;
  logic [fbfl_pkg::OFFSET_W-1:0]   out_offset;

  // Effective capacity: zero selects the default, then clamp to the pool size
  logic [CW-1:0] cap_sel;
  logic [CW-1:0] eff_cap;

  always_comb begin
    cap_sel = (pool_capacity == '0) ? CW'(fbfl_pkg::DEFAULT_BLOCKS) : CW'(pool_capacity);
    eff_cap = (cap_sel > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : cap_sel;
  end

  // Clearing pass: link i gets i+1, the last block gets the empty mark
  logic          sweep_last;
  logic [LW-1:0] sweep_wdata;

  always_comb begin
    sweep_last  = (CW'(sweep_idx) + CW'(1)) >= eff_cap;
    sweep_wdata = sweep_last ? EMPTY : (LW'(sweep_idx) + LW'(1));
  end

  // Request decode
  logic          accept;
  logic          is_alloc;
  logic          head_empty;
  logic          rec_ok;
  logic          res_granted;
  logic [LW-1:0] res_blk;
  logic          cap_write;

  assign req.ready  = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign is_alloc   = (req.mode == fbfl_pkg::MODE_ALLOC);
  assign head_empty = (head == EMPTY);
  assign rec_ok     = CW'(req.block_index) < eff_cap;
  assign cap_write  = cfg_wen && (cfg_index == fbfl_pkg::CFG_POOL_CAPACITY);

  always_comb begin
    res_granted = is_alloc ? !head_empty : rec_ok;
    res_blk     = is_alloc ? head : LW'(req.block_index);
  end

  // Byte offset: narrow index times 17-bit stride, one multiplier
  logic [SW-1:0] stride;
  logic [OW-1:0] blk_w;
  logic [OW-1:0] prod;

  always_comb begin
    stride = SW'(block_bytes) + SW'(LINK_BYTES);
    blk_w  = OW'(res_blk);
    prod   = blk_w * OW'(stride) + OW'(LINK_BYTES);
  end

  // Saturating in-use count
  always_comb begin
    in_use_next = in_use;
    if (res_granted) begin
      if (is_alloc) begin
        if (in_use != fbfl_pkg::USED_MAX) begin
          in_use_next = in_use + 1'b1;
        end
      end else if (in_use != '0) begin
        in_use_next = in_use - 1'b1;
      end
    end
  end

  // Link RAM ports: sweep or push write, pop read
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic          ram_re;
  logic [LW-1:0] ram_rdata;
  logic [CW-1:0] idx_w;

  assign idx_w = CW'(req.block_index);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_idx;
    ram_wdata = sweep_wdata;
    if (state == ST_INIT) begin
      ram_we = 1'b1;
    end else if (accept && !is_alloc && rec_ok) begin
      ram_we    = 1'b1;
      ram_waddr = idx_w[AW-1:0];
      ram_wdata = head;
    end
  end

  assign ram_re = accept && is_alloc && !head_empty;

  fbfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_capacity <= fbfl_pkg::CAP_RESET;
      block_bytes   <= fbfl_pkg::BYTES_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == fbfl_pkg::CFG_POOL_CAPACITY) begin
        pool_capacity <= cfg_data[fbfl_pkg::CAP_W-1:0];
      end else if (cfg_index == fbfl_pkg::CFG_BLOCK_BYTES) begin
        block_bytes <= cfg_data;
      end
    end
  end

  // Control: sweep, head, count
  always_ff @(posedge clk) begin
    if (rst || cap_write) begin
      state     <= ST_INIT;
      sweep_idx <= '0;
      head      <= '0;
      in_use    <= '0;
    end else begin
      unique case (state)
        ST_INIT: begin
          if (sweep_last) begin
            state <= ST_IDLE;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            in_use <= in_use_next;
            if (!is_alloc && rec_ok) begin
              head <= res_blk;
            end
            if (ram_re) begin
              state <= ST_POP;
            end
          end
        end
        ST_POP: begin
          head  <= ram_rdata;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  // Response register; loaded at the request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_granted <= res_granted;
      out_index   <= res_granted ? blk_w[fbfl_pkg::IDX_W-1:0] : '0;
      out_offset  <= res_granted ? prod[fbfl_pkg::OFFSET_W-1:0] : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.granted     = out_granted;
  assign rsp.given_index = out_index;
  assign rsp.byte_offset = out_offset;
  assign rsp.used_count  = in_use;

`ifndef SYNTHESIS
  // A pop cycle only follows a granted allocate transfer
  a_pop_after_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> $past(accept && is_alloc && !head_empty))
    else $error("pop state without a granted allocate");

  // No transfer while the link RAM is being rebuilt or a pop is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_INIT) || (state == ST_POP)) |-> !accept)
    else $error("request taken while busy");

  // A capacity write restarts the sweep and clears the count
  a_cap_write_clears: assert property (@(posedge clk) disable iff (rst)
    cap_write |=> (state == ST_INIT) && (in_use == '0) && (head == '0))
    else $error("capacity write did not rebuild the list");

  // A refused request reports zero index and offset
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> (out_index == '0) && (out_offset == '0))
    else $error("refused response carries a block");
`endif

endmodule

[tb/sv/fixed_block_free_list_allocator_unit_test.sv]
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_unit_test;

  // Register indexes the block decodes as no register at all
  localparam logic [fbfl_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [fbfl_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // One response as the allocator should return it
  typedef struct packed {
    logic                          granted;
    logic [fbfl_pkg::IDX_W-1:0]    given_index;
    logic [fbfl_pkg::OFFSET_W-1:0] byte_offset;
    logic [fbfl_pkg::USED_W-1:0]   used_count;
  } grant_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wen;
  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data;

  fbfl_req_if req_ch ();
  fbfl_rsp_if rsp_ch ();

  fixed_block_free_list_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the allocator: registers, free-list head, link memory, in-use count
  logic [fbfl_pkg::CAP_W-1:0]   cap_reg;
  logic [fbfl_pkg::BYTES_W-1:0] bytes_reg;
  logic [fbfl_pkg::CAP_W-1:0]   list_head;
  logic [fbfl_pkg::CAP_W-1:0]   link_mem [fbfl_pkg::MAX_BLOCKS_DEF];
  logic [fbfl_pkg::USED_W-1:0]  used_blocks;

  grant_t                       pending_grants[$];  // responses still owed by the block
  logic [fbfl_pkg::IDX_W-1:0]   blocks_out[$];      // handed-out blocks, for clean recycles
  int                           mismatches = 0;
  int                           send_idle_pct = 13;
  int                           recv_idle_pct = 63;

  // Clock: 12 ns period, first rising edge at 6 ns
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop; far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Zero picks the default pool size; anything above the RAM depth saturates.
  function automatic int unsigned usable_blocks();
    int unsigned n;
    n = (cap_reg == '0) ? fbfl_pkg::DEFAULT_BLOCKS : cap_reg;
    return (n > fbfl_pkg::MAX_BLOCKS_DEF) ? fbfl_pkg::MAX_BLOCKS_DEF : n;
  endfunction

  // Chain 0..n-1 in order, last one terminates; nothing in use.
  function automatic void rebuild_free_list();
    int unsigned n;
    n = usable_blocks();
    for (int i = 0; i < fbfl_pkg::MAX_BLOCKS_DEF; i++) begin
      link_mem[i] = (i + 1 < n) ? fbfl_pkg::CAP_W'(i + 1)
                                : fbfl_pkg::CAP_W'(fbfl_pkg::MAX_BLOCKS_DEF);
    end
    list_head   = '0;
    used_blocks = '0;
    blocks_out.delete();
  endfunction

  function automatic logic [fbfl_pkg::OFFSET_W-1:0] offset_of(
      logic [fbfl_pkg::IDX_W-1:0] idx);
    int unsigned stride;
    int unsigned pos;
    stride = bytes_reg + fbfl_pkg::LINK_BYTES_DEF;
    pos    = idx * stride + fbfl_pkg::LINK_BYTES_DEF;
    return pos[fbfl_pkg::OFFSET_W-1:0];  // wraps at 24 bits
  endfunction

  function automatic void apply_reg(logic [fbfl_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fbfl_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      fbfl_pkg::CFG_POOL_CAPACITY: begin
        cap_reg = data[fbfl_pkg::CAP_W-1:0];
        rebuild_free_list();
      end
      fbfl_pkg::CFG_BLOCK_BYTES: begin
        bytes_reg = data[fbfl_pkg::BYTES_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Pop on allocate, push on recycle; returns the response the block owes.
  function automatic grant_t predict_grant(fbfl_pkg::mode_t m,
                                           logic [fbfl_pkg::IDX_W-1:0] idx);
    grant_t r;
    r = '0;
    if (m == fbfl_pkg::MODE_ALLOC) begin
      if (list_head < fbfl_pkg::MAX_BLOCKS_DEF) begin
        r.granted     = 1'b1;
        r.given_index = list_head[fbfl_pkg::IDX_W-1:0];
        r.byte_offset = offset_of(r.given_index);
        list_head     = link_mem[r.given_index];
        if (used_blocks < fbfl_pkg::USED_MAX) used_blocks = used_blocks + 1'b1;
        blocks_out.push_back(r.given_index);
      end
    end else if (idx < usable_blocks()) begin
      // no double-free check; in-use floor is zero
      link_mem[idx] = list_head;
      list_head     = {1'b0, idx};
      r.granted     = 1'b1;
      r.given_index = idx;
      r.byte_offset = offset_of(idx);
      if (used_blocks != '0) used_blocks = used_blocks - 1'b1;
    end
    r.used_count = used_blocks;
    return r;
  endfunction

  task automatic check_field(string name, logic [fbfl_pkg::OFFSET_W-1:0] want,
                             logic [fbfl_pkg::OFFSET_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, i.e. pre-edge values.
  // Request transfer is predicted before the response transfer is checked, so
  // a response in the same cycle as its request would still find its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    grant_t want;
    if (rst) begin
      cap_reg   = fbfl_pkg::CAP_RESET;
      bytes_reg = fbfl_pkg::BYTES_RESET;
      rebuild_free_list();
      pending_grants.delete();
    end else begin
      if (cfg_wen) apply_reg(cfg_index, cfg_data);
      if (req_ch.valid && req_ch.ready) begin
        pending_grants.push_back(predict_grant(fbfl_pkg::mode_t'(req_ch.mode),
                                               req_ch.block_index));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_grants.size() == 0) begin
          mismatches++;
          $display("%0t: response transfer with nothing outstanding: granted %0h index %0h",
                   $time, rsp_ch.granted, rsp_ch.given_index);
        end else begin
          want = pending_grants.pop_front();
          check_field("granted", want.granted, rsp_ch.granted);
          check_field("given_index", want.given_index, rsp_ch.given_index);
          check_field("byte_offset", want.byte_offset, rsp_ch.byte_offset);
          check_field("used_count", want.used_count, rsp_ch.used_count);
        end
      end
    end
  end

  // Response side backpressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one request and hold it until the transfer. Gap cycles carry junk
  // payload with valid low. Valid is left high on return so back-to-back
  // requests never drop it within one step.
  task automatic send_request(fbfl_pkg::mode_t m, logic [fbfl_pkg::IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= 1'($urandom);
      req_ch.block_index <= fbfl_pkg::IDX_W'($urandom);
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= m;
    req_ch.block_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Go idle and wait out every owed response plus the allocate pop path.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Only called from an idle block (after settle).
  task automatic write_reg(logic [fbfl_pkg::CFG_IDX_W-1:0] idx,
                           logic [fbfl_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic alloc_n(int n);
    repeat (n) send_request(fbfl_pkg::MODE_ALLOC, fbfl_pkg::IDX_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset pool of eight: drain it, hit empty, refuse out-of-range recycles,
  // then check LIFO reuse.
  task automatic test_default_pool();
    alloc_n(9);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd8);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd255);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd3);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd7);
    alloc_n(3);
    settle();
  endtask

  // Recycle with nothing in use is taken and puts block 5 on the list twice,
  // which closes a loop; allocating 515 times must pin the count at its max.
  task automatic test_used_saturation();
    write_reg(fbfl_pkg::CFG_POOL_CAPACITY, 16'd8);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd5);
    alloc_n(515);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd2);
    settle();
  endtask

  // Register extremes: full pool with the widest stride, one-block pool,
  // zero stride, zero capacity, saturated capacity, and writes to spare
  // indexes that must change nothing.
  task automatic test_config_extremes();
    write_reg(fbfl_pkg::CFG_POOL_CAPACITY, 16'd256);
    write_reg(fbfl_pkg::CFG_BLOCK_BYTES, 16'hffff);
    alloc_n(257);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd255);
    alloc_n(1);  // block 255 at the largest offset
    settle();

    write_reg(fbfl_pkg::CFG_POOL_CAPACITY, 16'd1);
    write_reg(fbfl_pkg::CFG_BLOCK_BYTES, 16'd0);
    alloc_n(2);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd1);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd0);
    alloc_n(1);
    settle();

    write_reg(fbfl_pkg::CFG_POOL_CAPACITY, 16'd0);
    write_reg(fbfl_pkg::CFG_BLOCK_BYTES, 16'd1);
    alloc_n(9);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd8);
    settle();

    write_reg(fbfl_pkg::CFG_POOL_CAPACITY, 16'd300);
    write_reg(fbfl_pkg::CFG_BLOCK_BYTES, 16'd12345);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd255);
    alloc_n(2);
    settle();

    write_reg(fbfl_pkg::CFG_POOL_CAPACITY, 16'd511);
    write_reg(CFG_SPARE_2, 16'hffff);
    write_reg(CFG_SPARE_3, 16'hffff);
    send_request(fbfl_pkg::MODE_RECYCLE, 8'd200);
    alloc_n(2);
    settle();
  endtask

  // Mostly clean alloc/recycle traffic on the current pool, with some junk:
  // random-index recycles (out of range or double frees) mixed in.
  // Allocation bias drifts so the pool both empties and refills.
  task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
    int                         alloc_pct;
    int                         pick;
    int                         k;
    logic [15:0]                cap;
    logic [15:0]                stride;
    logic [fbfl_pkg::IDX_W-1:0] blk;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    alloc_pct     = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        settle();
        k = int'($urandom_range(0, 9));
        if (k < 6)       cap = 16'($urandom_range(1, 16));
        else if (k < 8)  cap = 16'($urandom_range(17, 256));
        else if (k == 8) cap = 16'd0;
        else             cap = 16'($urandom_range(257, 511));
        k = int'($urandom_range(0, 9));
        if (k == 0)      stride = 16'd0;
        else if (k == 1) stride = 16'hffff;
        else             stride = 16'($urandom);
        if ($urandom_range(0, 3) != 0) write_reg(fbfl_pkg::CFG_POOL_CAPACITY, cap);
        write_reg(fbfl_pkg::CFG_BLOCK_BYTES, stride);
      end
      if (i % 25 == 0) alloc_pct = int'($urandom_range(25, 80));
      if ($urandom_range(0, 99) < 12) begin
        send_request(fbfl_pkg::mode_t'(1'($urandom)), fbfl_pkg::IDX_W'($urandom));
      end else if (blocks_out.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        send_request(fbfl_pkg::MODE_ALLOC, fbfl_pkg::IDX_W'($urandom));
      end else begin
        pick = int'($urandom_range(0, blocks_out.size() - 1));
        blk  = blocks_out[pick];
        blocks_out.delete(pick);
        send_request(fbfl_pkg::MODE_RECYCLE, blk);
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                <= 1'b1;
    cfg_wen            <= 1'b0;
    cfg_index          <= fbfl_pkg::CFG_POOL_CAPACITY;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= fbfl_pkg::MODE_ALLOC;
    req_ch.block_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // block runs its clearing pass now; requests simply wait on ready
    // directed tests run with the sender idling 13% and the receiver 63%
    test_default_pool();
    test_used_saturation();
    test_config_extremes();

    test_random_traffic(200, 63, 13);
    test_random_traffic(200, 0, 0);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[fixed_block_free_list_allocator_unit.f]
src/fbfl_pkg.sv
src/fbfl_req_if.sv
src/fbfl_rsp_if.sv
src/fbfl_ram.sv
src/fixed_block_free_list_allocator_unit.sv
tb/sv/fixed_block_free_list_allocator_unit_test.sv
